// ===== sv/icd_pkg.sv =====
package icd_pkg;

    // Field widths
    localparam int BANK_DIGITS    = 8;
    localparam int ACCT_DIGITS    = 10;
    localparam int NUM_DIGITS     = BANK_DIGITS + ACCT_DIGITS;
    localparam int COUNTRY_W      = 14;
    localparam int SUM_W          = 15;
    localparam int FOLD_W         = 11;

    // Arithmetic constants
    localparam int MODULUS        = 97;
    localparam int CHECK_BASE     = 98;
    localparam int COUNTRY_RESET  = 1314;
    // Digits that follow the account: country (4) and "00" (2)
    localparam int TAIL_DIGITS    = 6;
    // 100 mod 97 scales the country digits past the trailing "00"
    localparam int COUNTRY_SCALE  = 100 % MODULUS;
    // 2^7 mod 97, used to fold the upper bits of a sum back down
    localparam int FOLD_MUL       = 128 % MODULUS;
    // floor(2^16 / 97), reciprocal for the final reduction
    localparam int RECIP          = 65536 / MODULUS;

    // Status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ACCT = 2'd1;
    localparam logic [1:0] ST_BANK = 2'd2;

    typedef struct packed {
        logic [31:0] bank_code_bcd;
        logic [39:0] account_bcd;
    } icd_in_t;

    typedef struct packed {
        logic [1:0] status;
        logic [6:0] check_value;
        logic [7:0] check_bcd;
    } icd_out_t;

    // Weighted digit sum between the sum and reduce stages
    typedef struct packed {
        logic             valid;
        logic [1:0]       status;
        logic [SUM_W-1:0] sum;
    } icd_sum_t;

    // Remainder between the reduce and format stages
    typedef struct packed {
        logic       valid;
        logic [1:0] status;
        logic [6:0] rem;
    } icd_rem_t;

    // 10^k mod 97, evaluated at elaboration for constant k
    function automatic logic [6:0] pow10_mod(input int k);
        int r;
        int i;
        r = 1;
        for (i = 0; i < k; i++)
        begin
            r = (r * 10) % MODULUS;
        end
        return 7'(r);
    endfunction

endpackage

// ===== sv/icd_digit_sum.sv =====
module icd_digit_sum
    import icd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  icd_in_t              req,
    input  logic [COUNTRY_W-1:0] country,
    output icd_sum_t             sum_o
);

    logic                 valid1_reg;
    logic [1:0]           status1_reg;
    logic [12:0]          grp_reg [3];
    logic [13:0]          cterm_reg;

    logic [1:0]           status1_next;
    logic [12:0]          grp_next [3];
    logic [13:0]          cterm_next;
    logic [3:0]           dig [NUM_DIGITS];
    logic                 acct_bad;
    logic                 bank_bad;

    logic                 valid2_reg;
    logic [1:0]           status2_reg;
    logic [SUM_W-1:0]     sum2_reg;
    logic [SUM_W-1:0]     sum2_next;

    // Stage 1: digit check, weighted digits in three groups, country term
    always_comb
    begin
        acct_bad = 1'b0;
        bank_bad = 1'b0;
        for (int j = 0; j < ACCT_DIGITS; j++)
        begin
            dig[j] = req.account_bcd[4*j +: 4];
            if (req.account_bcd[4*j +: 4] > 4'd9)
                acct_bad = 1'b1;
        end
        for (int j = 0; j < BANK_DIGITS; j++)
        begin
            dig[ACCT_DIGITS + j] = req.bank_code_bcd[4*j +: 4];
            if (req.bank_code_bcd[4*j +: 4] > 4'd9)
                bank_bad = 1'b1;
        end
        if (acct_bad)
            status1_next = ST_ACCT;
        else if (bank_bad)
            status1_next = ST_BANK;
        else
            status1_next = ST_OK;

        for (int g = 0; g < 3; g++)
        begin
            grp_next[g] = '0;
            for (int k = 0; k < NUM_DIGITS / 3; k++)
            begin
                grp_next[g] = grp_next[g]
                    + 13'(dig[g*(NUM_DIGITS/3) + k])
                      * pow10_mod(TAIL_DIGITS + g*(NUM_DIGITS/3) + k);
            end
        end

        // country*100 mod 97 with the upper seven bits folded by 128 mod 97
        cterm_next = 14'(country[6:0] * COUNTRY_SCALE)
                   + 14'(country[13:7] * ((COUNTRY_SCALE * FOLD_MUL) % MODULUS));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid1_reg <= 1'b0;
        else
            valid1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        status1_reg <= status1_next;
        grp_reg     <= grp_next;
        cterm_reg   <= cterm_next;
    end

    // Stage 2: total of the groups and the country term
    assign sum2_next = SUM_W'(grp_reg[0]) + SUM_W'(grp_reg[1])
                     + SUM_W'(grp_reg[2]) + SUM_W'(cterm_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid2_reg <= 1'b0;
        else
            valid2_reg <= valid1_reg;
    end

    always_ff @(posedge clk)
    begin
        status2_reg <= status1_reg;
        sum2_reg    <= sum2_next;
    end

    assign sum_o.valid  = valid2_reg;
    assign sum_o.status = status2_reg;
    assign sum_o.sum    = sum2_reg;

endmodule

// ===== sv/icd_mod_reduce.sv =====
module icd_mod_reduce
    import icd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  icd_sum_t sum_i,
    output icd_rem_t rem_o
);

    logic              valid3_reg;
    logic [1:0]        status3_reg;
    logic [FOLD_W-1:0] fold3_reg;
    logic [FOLD_W-1:0] fold3_next;
    logic [12:0]       fold_a;

    logic              valid4_reg;
    logic [1:0]        status4_reg;
    logic [6:0]        rem4_reg;
    logic [6:0]        rem4_next;
    logic [20:0]       prod;
    logic [4:0]        quot;
    logic [FOLD_W-1:0] diff;

    // Stage 3: two folds of the upper bits, 2^7 = 31 (mod 97)
    always_comb
    begin
        fold_a     = 13'(sum_i.sum[SUM_W-1:7] * FOLD_MUL) + 13'(sum_i.sum[6:0]);
        fold3_next = FOLD_W'(fold_a[12:7] * FOLD_MUL) + FOLD_W'(fold_a[6:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid3_reg <= 1'b0;
        else
            valid3_reg <= sum_i.valid;
    end

    always_ff @(posedge clk)
    begin
        status3_reg <= sum_i.status;
        fold3_reg   <= fold3_next;
    end

    // Stage 4: reciprocal quotient (low by at most one), then one correction
    always_comb
    begin
        prod = 21'(fold3_reg * RECIP);
        quot = prod[20:16];
        diff = fold3_reg - FOLD_W'(quot * MODULUS);
        if (diff >= FOLD_W'(MODULUS))
            diff = diff - FOLD_W'(MODULUS);
        rem4_next = diff[6:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid4_reg <= 1'b0;
        else
            valid4_reg <= valid3_reg;
    end

    always_ff @(posedge clk)
    begin
        status4_reg <= status3_reg;
        rem4_reg    <= rem4_next;
    end

    assign rem_o.valid  = valid4_reg;
    assign rem_o.status = status4_reg;
    assign rem_o.rem    = rem4_reg;

endmodule

// ===== sv/icd_format.sv =====
module icd_format
    import icd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  icd_rem_t rem_i,
    output logic     done,
    output icd_out_t rsp
);

    logic       done_reg;
    icd_out_t   rsp_reg;
    icd_out_t   rsp_next;
    logic [6:0] chk;
    logic [14:0] tens_prod;
    logic [3:0] tens;
    logic [3:0] ones;

    // Check digits and BCD split; tens = chk*205 >> 11 is exact below 1029
    always_comb
    begin
        chk       = 7'(CHECK_BASE) - rem_i.rem;
        tens_prod = 15'(chk * 205);
        tens      = tens_prod[14:11];
        ones      = 4'(chk - 7'(tens * 10));
        rsp_next.status = rem_i.status;
        if (rem_i.status == ST_OK)
        begin
            rsp_next.check_value = chk;
            rsp_next.check_bcd   = {tens, ones};
        end
        else
        begin
            rsp_next.check_value = '0;
            rsp_next.check_bcd   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= rem_i.valid;
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

// ===== sv/iban_check_digit_de.sv =====
// Channel   Direction  Handshake               Word
// req       in         start (busy always low)  icd_in_t: bank code, account BCD
// rsp       out        done strobe, one cycle   icd_out_t: status, check digits
// cfg       in         cfg_we                   cfg_wdata: country digits
//
// One word accepted per cycle; each result passes through five register
// stages after its start edge: digit sum, total, fold, reduce, format.
// Reset clears the stage valid bits and loads country digits 1314.
// Nothing stalls: the receiver takes every result, so busy stays low.
module iban_check_digit_de
    import icd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  icd_in_t              req,
    output logic                 done,
    output icd_out_t             rsp,
    input  logic                 cfg_we,
    input  logic [COUNTRY_W-1:0] cfg_wdata
);

    logic [COUNTRY_W-1:0] country_reg;
    icd_sum_t             sum_s;
    icd_rem_t             rem_s;

    // Country digits register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            country_reg <= COUNTRY_W'(COUNTRY_RESET);
        else if (cfg_we)
            country_reg <= cfg_wdata;
    end

    assign busy = 1'b0;

    icd_digit_sum u_sum (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start),
        .req      (req),
        .country  (country_reg),
        .sum_o    (sum_s)
    );

    icd_mod_reduce u_reduce (
        .clk   (clk),
        .rst_n (rst_n),
        .sum_i (sum_s),
        .rem_o (rem_s)
    );

    icd_format u_format (
        .clk   (clk),
        .rst_n (rst_n),
        .rem_i (rem_s),
        .done  (done),
        .rsp   (rsp)
    );

`ifndef ASSERT_OFF
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##5 done)
        else $error("accepted word produced no result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !start |-> ##5 !done)
        else $error("result without accepted word");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.status != ST_OK |-> rsp.check_value == 7'd0 && rsp.check_bcd == 8'd0)
        else $error("invalid word carries check digits");

    a_check_range: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.status == ST_OK |-> rsp.check_value >= 7'd2 && rsp.check_value <= 7'd98)
        else $error("check value out of range");
`endif

endmodule

// ===== tb/iban_check_digit_de_test.sv =====
module iban_check_digit_de_test;
    import icd_pkg::*;

    localparam int CLK_HALF    = 10;
    localparam int RESET_CYC   = 7;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYC   = 12;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    icd_in_t              req;
    logic                 done;
    icd_out_t             rsp;
    logic                 cfg_we;
    logic [COUNTRY_W-1:0] cfg_wdata;

    // Checker state: expected results in acceptance order
    icd_out_t             expected_checks[$];
    icd_out_t             oldest_check;
    logic [COUNTRY_W-1:0] country_setting;
    int                   mismatches;
    int                   words_sent;
    int                   words_checked;
    int                   valid_seen;
    int                   acct_err_seen;
    int                   bank_err_seen;
    int                   cycle_count;

    iban_check_digit_de dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #CLK_HALF clk = ~clk;

    // Mod 97 check digits for one word, under the current country setting
    function automatic icd_out_t predict_check(input logic [31:0] bank,
                                               input logic [39:0] acct);
        icd_out_t r;
        int       rem;
        int       chk;
        int       i;
        r = '0;
        // account digits are checked before the bank code
        for (i = 0; i < ACCT_DIGITS; i++)
        begin
            if (acct[4*i +: 4] > 4'd9)
            begin
                r.status = ST_ACCT;
                return r;
            end
        end
        for (i = 0; i < BANK_DIGITS; i++)
        begin
            if (bank[4*i +: 4] > 4'd9)
            begin
                r.status = ST_BANK;
                return r;
            end
        end
        rem = 0;
        for (i = BANK_DIGITS - 1; i >= 0; i--)
        begin
            rem = (rem * 10 + int'(bank[4*i +: 4])) % MODULUS;
        end
        for (i = ACCT_DIGITS - 1; i >= 0; i--)
        begin
            rem = (rem * 10 + int'(acct[4*i +: 4])) % MODULUS;
        end
        // country register is taken as a plain binary number, then "00"
        rem = (rem * 10000 + int'(country_setting)) % MODULUS;
        rem = (rem * 100) % MODULUS;
        chk = CHECK_BASE - rem;
        r.status      = ST_OK;
        r.check_value = chk[6:0];
        r.check_bcd   = {4'(chk / 10), 4'(chk % 10)};
        return r;
    endfunction

    // Random BCD digits, sometimes with leading zero padding
    function automatic logic [39:0] random_bcd(input int ndig);
        logic [39:0] v;
        int          keep;
        int          i;
        v    = '0;
        keep = ndig;
        if ($urandom_range(0, 3) == 0)
        begin
            keep = $urandom_range(0, ndig);
        end
        for (i = 0; i < keep; i++)
        begin
            v[4*i +: 4] = 4'($urandom_range(0, 9));
        end
        return v;
    endfunction

    // Puts a non-decimal nibble at a random digit position
    function automatic logic [39:0] spoil_digit(input logic [39:0] v, input int ndig);
        logic [39:0] r;
        int          pos;
        r   = v;
        pos = $urandom_range(0, ndig - 1);
        r[4*pos +: 4] = 4'($urandom_range(10, 15));
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH @%0t %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Drive one word and hold it until accepted
    task automatic send_word(input logic [31:0] bank, input logic [39:0] acct);
        icd_in_t w;
        w.bank_code_bcd = bank;
        w.account_bcd   = acct;
        @(negedge clk);
        start <= 1'b1;
        req   <= w;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        expected_checks.push_back(predict_check(bank, acct));
        words_sent++;
    endtask

    // Sender gap: start held low, with n setting its length
    task automatic pause_sender(input int n);
        @(negedge clk);
        start <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    // Stop sending and wait for every expected word
    task automatic drain_results;
        @(negedge clk);
        start <= 1'b0;
        while (expected_checks.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Country register write; block must be idle
    task automatic set_country(input logic [COUNTRY_W-1:0] v);
        drain_results();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        country_setting = v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Mostly well-formed requests, some broken digits, some raw noise
    task automatic send_random_word;
        logic [39:0] acct;
        logic [39:0] bank;
        int          kind;
        acct = random_bcd(ACCT_DIGITS);
        bank = random_bcd(BANK_DIGITS);
        kind = $urandom_range(0, 19);
        if (kind inside {[14:15]})
        begin
            acct = spoil_digit(acct, ACCT_DIGITS);
        end
        else if (kind inside {[16:17]})
        begin
            bank = spoil_digit(bank, BANK_DIGITS);
        end
        else if (kind == 18)
        begin
            acct = spoil_digit(acct, ACCT_DIGITS);
            bank = spoil_digit(bank, BANK_DIGITS);
        end
        else if (kind == 19)
        begin
            acct = 40'({$urandom, $urandom});
            bank = {8'h00, $urandom};
        end
        send_word(bank[31:0], acct);
    endtask

    // Default country after reset, known example and digit extremes
    task automatic test_reset_default;
        send_word(32'h37040044, 40'h0532013000);
        send_word(32'h00000000, 40'h0000000000);
        send_word(32'h99999999, 40'h9999999999);
        send_word(32'h00000001, 40'h0000000000);
        send_word(32'h12345678, 40'h0000000123);
        send_word(32'h90000000, 40'h9000000000);
        drain_results();
    endtask

    // Bad nibbles at both ends of each field, account taking priority
    task automatic test_digit_errors;
        send_word(32'h37040044, 40'h000000000A);
        send_word(32'h37040044, 40'hF532013000);
        send_word(32'hA7040044, 40'h0532013000);
        send_word(32'h3704004F, 40'h0532013000);
        send_word(32'hFFFFFFFF, 40'hFFFFFFFFFF);
        send_word(32'hB0000000, 40'h00000C0000);
        send_word(32'h99999999, 40'hA999999999);
        send_word(32'h9999999E, 40'h9999999999);
        pause_sender(3);
        send_word(32'h00000000, 40'h000000000F);
        drain_results();
    endtask

    // Register extremes, including values above 9999
    task automatic test_country_extremes;
        logic [COUNTRY_W-1:0] settings[5];
        int                   s;
        int                   k;
        settings[0] = 14'd0;
        settings[1] = 14'd9999;
        settings[2] = 14'h3FFF;
        settings[3] = 14'd1;
        settings[4] = 14'(COUNTRY_RESET);
        for (s = 0; s < 5; s++)
        begin
            set_country(settings[s]);
            send_word(32'h37040044, 40'h0532013000);
            send_word(32'h99999999, 40'h9999999999);
            send_word(32'h00000000, 40'h0000000000);
            for (k = 0; k < 7; k++)
            begin
                send_random_word();
            end
        end
        drain_results();
    endtask

    // Random traffic across country settings; the last phase runs back to back
    task automatic test_random_traffic;
        int phase;
        int k;
        int gap_odds;
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: set_country(14'($urandom_range(0, 9999)));
                1: set_country(14'($urandom_range(10000, 16383)));
                2: set_country(14'($urandom_range(0, 9999)));
                default: set_country(14'(COUNTRY_RESET));
            endcase
            for (k = 0; k < 400; k++)
            begin
                // gap density changes every 50 words, so some stretches run dense
                if (k % 50 == 0)
                begin
                    gap_odds = $urandom_range(0, 4);
                end
                send_random_word();
                if (phase < 3 && gap_odds != 0 && $urandom_range(0, gap_odds + 2) == 0)
                begin
                    pause_sender($urandom_range(1, 12));
                end
            end
        end
        drain_results();
    endtask

    // Result checker: the receiver takes every strobed word
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_checks.size() == 0)
            begin
                report_mismatch("unexpected result word, status", int'(rsp.status), -1);
            end
            else
            begin
                oldest_check = expected_checks.pop_front();
                if (rsp.status != oldest_check.status)
                begin
                    report_mismatch("status", int'(rsp.status),
                                    int'(oldest_check.status));
                end
                if (rsp.check_value != oldest_check.check_value)
                begin
                    report_mismatch("check_value", int'(rsp.check_value),
                                    int'(oldest_check.check_value));
                end
                if (rsp.check_bcd != oldest_check.check_bcd)
                begin
                    report_mismatch("check_bcd", int'(rsp.check_bcd),
                                    int'(oldest_check.check_bcd));
                end
                case (oldest_check.status)
                    ST_OK:   valid_seen++;
                    ST_ACCT: acct_err_seen++;
                    default: bank_err_seen++;
                endcase
                words_checked++;
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_checks.size());
            $display("iban_check_digit_de_test: errors");
            $finish;
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        start           = 1'b0;
        req             = '0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        country_setting = 14'(COUNTRY_RESET);
        mismatches      = 0;
        words_sent      = 0;
        words_checked   = 0;
        valid_seen      = 0;
        acct_err_seen   = 0;
        bank_err_seen   = 0;
        cycle_count     = 0;
        repeat (RESET_CYC) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_default();
        test_digit_errors();
        test_country_extremes();
        test_random_traffic();

        drain_results();
        repeat (DRAIN_CYC) @(posedge clk);
        $display("%0d words sent, %0d results checked", words_sent, words_checked);
        $display("%0d valid, %0d bad account digit, %0d bad bank digit; country 0..16383",
                 valid_seen, acct_err_seen, bank_err_seen);
        if (mismatches == 0)
        begin
            $display("iban_check_digit_de_test: clean");
        end
        else
        begin
            $display("iban_check_digit_de_test: errors");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/icd_pkg.sv
sv/icd_digit_sum.sv
sv/icd_mod_reduce.sv
sv/icd_format.sv
sv/iban_check_digit_de.sv
tb/iban_check_digit_de_test.sv
